FILE: src/tbd_pkg.sv
package tbd_pkg;

    localparam logic [1:0] MODE_FALLBACK   = 2'd1;
    localparam logic [1:0] MODE_BYTE_LEVEL = 2'd2;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] SEQ_B0   = 8'hE2;
    localparam logic [7:0] SEQ_B1   = 8'h96;
    localparam logic [7:0] SEQ_B2   = 8'h81;

    typedef enum logic [1:0] {
        DK_RAW,
        DK_DEC,
        DK_SPACE,
        DK_BYTE
    } tbd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_BYTE
    } tbd_bk_state_t;

    typedef struct packed {
        tbd_kind_t  kind;
        logic       bank;
        logic [7:0] value;
        logic       ovf;
        logic       bad_hex;
    } tbd_desc_t;

    typedef struct packed {
        logic       raw_we;
        logic       dec_we;
        logic [7:0] raw_data;
        logic [7:0] dec_data;
    } tbd_wr_t;

    // inverse byte-to-unicode map, top bit set when the code point has a byte
    function automatic logic [8:0] tbd_cp_to_byte(input logic [10:0] cp);
        logic [8:0]  r;
        logic [10:0] shifted;
        r = 9'd0;
        shifted = cp - 11'd162;
        if ((cp >= 11'd33 && cp <= 11'd126) || (cp >= 11'd161 && cp <= 11'd172) ||
            (cp >= 11'd174 && cp <= 11'd288))
        begin
            r = {1'b1, cp[7:0]};
        end
        else if (cp >= 11'd289 && cp <= 11'd322)
        begin
            r = {1'b1, shifted[7:0]};
        end
        else if (cp == 11'd323)
        begin
            r = {1'b1, 8'd173};
        end
        return r;
    endfunction

    // upper-case hex digit, top bit set when valid
    function automatic logic [4:0] tbd_hex(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] alpha;
        r = 5'd0;
        alpha = c - 8'd55;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, alpha[3:0]};
        end
        return r;
    endfunction

endpackage

FILE: src/token_byte_decoder.sv
// token byte decoder
// input channel: one byte of a vocabulary token per transaction (in_byte), in_last on
// the final byte; a transaction completes when in_valid is high and in_stall is low.
// output channel: one decoded byte per transaction, out_last on the final one, with
// overflow and bad_hex repeated on every byte of the token.
// config channel: cfg_data sets vocab_mode (0 raw, 1 byte fallback, 2 byte level),
// always ready; the mode seen with the final input byte decides the token.
// while in_stall is low, input bytes are taken one per cycle into one of two token banks;
// a finished token goes to a two-entry queue, so a second token can be taken while the
// first drains. in_stall is high while both banks hold undrained tokens.
// the read side leaves idle for a queued token, fetches its bytes from the bank through a
// registered memory read and sends each one through the output register; a <0xHH> token
// sends its decoded value from the queue entry without a fetch. bytes then follow one per
// cycle while out_stall is low, with gaps while the window refills after a replacement.
// while out_stall is high with out_valid set, the output register holds and the read side
// fetches only until its three-byte window is full; input keeps flowing until both banks are full.
// reset clears all control state and sets the mode to raw; no clearing pass is needed.
module token_byte_decoder
    import tbd_pkg::*;
#(
    parameter int MAX_TOKEN_BYTES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       overflow,
    output logic       bad_hex
);

    localparam int IDXW = $clog2(MAX_TOKEN_BYTES);
    localparam int LENW = $clog2(MAX_TOKEN_BYTES + 1);

    logic            q_full;
    logic            q_push;
    tbd_desc_t       push_desc;
    logic [LENW-1:0] push_len;
    logic            q_pop;
    logic            q_valid;
    tbd_desc_t       head_desc;
    logic [LENW-1:0] head_len;
    tbd_wr_t         wr;
    logic [IDXW:0]   raw_addr;
    logic [IDXW:0]   dec_addr;

    tbd_front #(
        .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (push_desc),
        .q_len    (push_len),
        .wr       (wr),
        .raw_addr (raw_addr),
        .dec_addr (dec_addr)
    );

    tbd_queue #(
        .LENW(LENW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_desc(push_desc),
        .push_len (push_len),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head_desc(head_desc),
        .head_len (head_len)
    );

    tbd_back #(
        .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .raw_addr (raw_addr),
        .dec_addr (dec_addr),
        .q_valid  (q_valid),
        .q_desc   (head_desc),
        .q_len    (head_len),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte (out_byte),
        .out_last (out_last),
        .overflow (overflow),
        .bad_hex  (bad_hex)
    );

endmodule

FILE: src/tbd_front.sv
module tbd_front
    import tbd_pkg::*;
#(
    parameter int MAX_TOKEN_BYTES = 64,
    localparam int IDXW = $clog2(MAX_TOKEN_BYTES),
    localparam int LENW = $clog2(MAX_TOKEN_BYTES + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            q_full,
    output logic            q_push,
    output tbd_desc_t       q_desc,
    output logic [LENW-1:0] q_len,
    output tbd_wr_t         wr,
    output logic [IDXW:0]   raw_addr,
    output logic [IDXW:0]   dec_addr
);

    logic [1:0]      mode_reg;
    logic [LENW-1:0] raw_len_reg, raw_len_next;
    logic [LENW-1:0] dec_len_reg, dec_len_next;
    logic            trunc_reg, trunc_next;
    logic            mf_reg, mf_next;
    logic            cont_reg, cont_next;
    logic [4:0]      part_reg, part_next;
    logic            pfx_reg, pfx_next;
    logic [7:0]      b3_reg, b3_next;
    logic [7:0]      b4_reg, b4_next;
    logic [7:0]      b5_reg, b5_next;
    logic            bank_reg, bank_next;
    logic            accept;
    logic            stored;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign stored    = raw_len_reg != LENW'(MAX_TOKEN_BYTES);
    assign raw_addr  = {bank_reg, raw_len_reg[IDXW-1:0]};
    assign dec_addr  = {bank_reg, dec_len_reg[IDXW-1:0]};

    always_comb
    begin
        logic [10:0] cp;
        logic [8:0]  mapped;
        logic [4:0]  hi;
        logic [4:0]  lo;
        logic        push_cp;
        logic        byte_form;

        raw_len_next = raw_len_reg;
        dec_len_next = dec_len_reg;
        trunc_next   = trunc_reg;
        mf_next      = mf_reg;
        cont_next    = cont_reg;
        part_next    = part_reg;
        pfx_next     = pfx_reg;
        b3_next      = b3_reg;
        b4_next      = b4_reg;
        b5_next      = b5_reg;
        bank_next    = bank_reg;
        push_cp      = 1'b0;
        wr.raw_we    = accept && stored;
        wr.raw_data  = in_byte;
        wr.dec_we    = 1'b0;

        if (cont_reg)
        begin
            cp = {part_reg, in_byte[5:0]};
        end
        else
        begin
            cp = {3'b000, in_byte};
        end
        mapped      = tbd_cp_to_byte(cp);
        wr.dec_data = mapped[7:0];

        if (accept)
        begin
            if (stored)
            begin
                raw_len_next = raw_len_reg + LENW'(1);
                if (raw_len_reg == LENW'(0))
                begin
                    pfx_next = in_byte == CH_LT;
                end
                else if (raw_len_reg == LENW'(1))
                begin
                    pfx_next = pfx_reg && (in_byte == CH_ZERO);
                end
                else if (raw_len_reg == LENW'(2))
                begin
                    pfx_next = pfx_reg && (in_byte == CH_X);
                end
                else if (raw_len_reg == LENW'(3))
                begin
                    b3_next = in_byte;
                end
                else if (raw_len_reg == LENW'(4))
                begin
                    b4_next = in_byte;
                end
                else if (raw_len_reg == LENW'(5))
                begin
                    b5_next = in_byte;
                end

                if (!mf_reg)
                begin
                    if (cont_reg)
                    begin
                        if (in_byte[7:6] != 2'b10)
                        begin
                            mf_next = 1'b1;
                        end
                        else
                        begin
                            cont_next = 1'b0;
                            push_cp   = 1'b1;
                        end
                    end
                    else if (!in_byte[7])
                    begin
                        push_cp = 1'b1;
                    end
                    else if (in_byte >= 8'hC2 && in_byte <= 8'hDF)
                    begin
                        part_next = in_byte[4:0];
                        cont_next = 1'b1;
                    end
                    else
                    begin
                        mf_next = 1'b1;
                    end
                end
            end
            else
            begin
                trunc_next = 1'b1;
            end
        end

        if (push_cp)
        begin
            if (!mapped[8] || dec_len_reg == LENW'(MAX_TOKEN_BYTES))
            begin
                mf_next = 1'b1;
            end
            else
            begin
                wr.dec_we    = 1'b1;
                dec_len_next = dec_len_reg + LENW'(1);
            end
        end

        hi        = tbd_hex(b3_next);
        lo        = tbd_hex(b4_next);
        byte_form = (raw_len_next == LENW'(6)) && pfx_next && (b5_next == CH_GT);

        q_push          = accept && in_last;
        q_desc.bank     = bank_reg;
        q_desc.value    = {hi[3:0], lo[3:0]};
        q_desc.ovf      = trunc_next;
        q_desc.bad_hex  = 1'b0;
        q_desc.kind     = DK_RAW;
        q_len           = raw_len_next;
        unique case (mode_reg)
            MODE_BYTE_LEVEL:
            begin
                if (!mf_next && !cont_next)
                begin
                    q_desc.kind = DK_DEC;
                    q_len       = dec_len_next;
                end
            end
            MODE_FALLBACK:
            begin
                if (byte_form && hi[4] && lo[4])
                begin
                    q_desc.kind = DK_BYTE;
                end
                else
                begin
                    q_desc.kind    = DK_SPACE;
                    q_desc.bad_hex = byte_form;
                end
            end
            default:
            begin
                q_desc.kind = DK_RAW;
            end
        endcase

        // token handed over, start the next one in the other bank
        if (q_push)
        begin
            raw_len_next = '0;
            dec_len_next = '0;
            trunc_next   = 1'b0;
            mf_next      = 1'b0;
            cont_next    = 1'b0;
            part_next    = '0;
            pfx_next     = 1'b0;
            bank_next    = !bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            raw_len_reg <= '0;
            dec_len_reg <= '0;
            trunc_reg   <= 1'b0;
            mf_reg      <= 1'b0;
            cont_reg    <= 1'b0;
            part_reg    <= '0;
            pfx_reg     <= 1'b0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            raw_len_reg <= raw_len_next;
            dec_len_reg <= dec_len_next;
            trunc_reg   <= trunc_next;
            mf_reg      <= mf_next;
            cont_reg    <= cont_next;
            part_reg    <= part_next;
            pfx_reg     <= pfx_next;
            bank_reg    <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b3_reg <= b3_next;
        b4_reg <= b4_next;
        b5_reg <= b5_next;
    end

endmodule

FILE: src/tbd_queue.sv
module tbd_queue
    import tbd_pkg::*;
#(
    parameter int LENW = 7
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tbd_desc_t       push_desc,
    input  logic [LENW-1:0] push_len,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output tbd_desc_t       head_desc,
    output logic [LENW-1:0] head_len
);

    tbd_desc_t       slot_desc_reg [2];
    logic [LENW-1:0] slot_len_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg, cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign valid     = cnt_reg != 2'd0;
    assign head_desc = slot_desc_reg[rd_ptr_reg];
    assign head_len  = slot_len_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_desc_reg[wr_ptr_reg] <= push_desc;
            slot_len_reg[wr_ptr_reg]  <= push_len;
        end
    end

endmodule

FILE: src/tbd_back.sv
module tbd_back
    import tbd_pkg::*;
#(
    parameter int MAX_TOKEN_BYTES = 64,
    localparam int IDXW = $clog2(MAX_TOKEN_BYTES),
    localparam int LENW = $clog2(MAX_TOKEN_BYTES + 1),
    localparam int MEM_DEPTH = 2 * (2 ** IDXW)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tbd_wr_t         wr,
    input  logic [IDXW:0]   raw_addr,
    input  logic [IDXW:0]   dec_addr,
    input  logic            q_valid,
    input  tbd_desc_t       q_desc,
    input  logic [LENW-1:0] q_len,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            overflow,
    output logic            bad_hex
);

    logic [7:0]      raw_mem [MEM_DEPTH];
    logic [7:0]      dec_mem [MEM_DEPTH];
    logic [7:0]      raw_q_reg;
    logic [7:0]      dec_q_reg;
    logic [IDXW:0]   rd_addr;

    tbd_bk_state_t   state_reg, state_next;
    logic [LENW-1:0] fetch_idx_reg, fetch_idx_next;
    logic [1:0]      win_cnt_reg, win_cnt_next;
    logic            pend_reg, pend_next;
    logic [7:0]      win_reg [3];
    logic [7:0]      win_next [3];
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic            overflow_reg;
    logic            bad_hex_reg;

    logic [7:0]      mem_q;
    logic [7:0]      ew [3];
    logic [1:0]      avail;
    logic [1:0]      take;
    logic [1:0]      rem;
    logic            fetch_done;
    logic            seq_match;
    logic            can_emit;
    logic            slot_free;
    logic            emit;
    logic            emit_last;
    logic [7:0]      emit_byte;
    logic            issue;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign overflow  = overflow_reg;
    assign bad_hex   = bad_hex_reg;

    assign rd_addr   = {q_desc.bank, fetch_idx_reg[IDXW-1:0]};
    assign mem_q     = (q_desc.kind == DK_DEC) ? dec_q_reg : raw_q_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (wr.raw_we)
        begin
            raw_mem[raw_addr] <= wr.raw_data;
        end
        if (wr.dec_we)
        begin
            dec_mem[dec_addr] <= wr.dec_data;
        end
        raw_q_reg <= raw_mem[rd_addr];
        dec_q_reg <= dec_mem[rd_addr];
    end

    // three-byte window: held bytes first, then the byte just read
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ew[k] = (win_cnt_reg > 2'(k)) ? win_reg[k] : mem_q;
        end
        avail      = win_cnt_reg + {1'b0, pend_reg};
        fetch_done = fetch_idx_reg == q_len;
        seq_match  = (q_desc.kind == DK_SPACE) && (avail == 2'd3) &&
                     (ew[0] == SEQ_B0) && (ew[1] == SEQ_B1) && (ew[2] == SEQ_B2);
        can_emit   = (avail != 2'd0) &&
                     ((q_desc.kind != DK_SPACE) || (avail == 2'd3) || fetch_done);
    end

    // outputs of the sequencer
    always_comb
    begin
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_byte = ew[0];
        take      = 2'd0;
        q_pop     = 1'b0;
        unique case (state_reg)
            BK_RUN:
            begin
                if (can_emit && slot_free)
                begin
                    emit      = 1'b1;
                    take      = seq_match ? 2'd3 : 2'd1;
                    emit_byte = seq_match ? CH_SPACE : ew[0];
                end
            end
            BK_BYTE:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    emit_byte = q_desc.value;
                    q_pop     = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        rem   = avail - take;
        issue = (state_reg == BK_RUN) && !fetch_done && (rem != 2'd3);
        if (state_reg == BK_RUN && emit && fetch_done && rem == 2'd0)
        begin
            emit_last = 1'b1;
            q_pop     = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_desc.kind == DK_BYTE) ? BK_BYTE : BK_RUN;
                end
            end
            BK_RUN, BK_BYTE:
            begin
                if (q_pop)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fetch_idx_next = fetch_idx_reg;
        pend_next      = issue;
        win_cnt_next   = rem;
        if (issue)
        begin
            fetch_idx_next = fetch_idx_reg + LENW'(1);
        end
        if (take == 2'd1)
        begin
            win_next[0] = ew[1];
            win_next[1] = ew[2];
            win_next[2] = ew[2];
        end
        else
        begin
            win_next = ew;
        end
        if (state_reg != BK_RUN)
        begin
            fetch_idx_next = '0;
            win_cnt_next   = '0;
        end
        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fetch_idx_reg <= '0;
            win_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fetch_idx_reg <= fetch_idx_next;
            win_cnt_reg   <= win_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            overflow_reg <= q_desc.ovf;
            bad_hex_reg  <= q_desc.bad_hex;
        end
    end

endmodule
